/* rtl/msq_pkg.sv */
`default_nettype none
package msq_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_OFFSET   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_STEP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_DUR  = 3'd4;

  localparam logic [6:0]  RST_KEY_OFFSET  = 7'd48;
  localparam logic [7:0]  RST_LAST_STEP   = 8'd110;
  localparam logic [6:0]  RST_VELOCITY    = 7'd80;
  localparam logic [3:0]  RST_CHANNEL     = 4'd0;
  localparam logic [15:0] RST_DEFAULT_DUR = 16'd100;

  localparam logic [7:0] STATUS_OFF = 8'h80;
  localparam logic [7:0] STATUS_ON  = 8'h90;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_REL   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_SCHED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [6:0]  key_offset;
    logic [7:0]  last_step;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [15:0] default_duration;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  step;
    logic [15:0] offset;
    logic [15:0] duration;
    logic [6:0]  note;
  } entry_t;

  typedef struct packed {
    logic        en;
    kind_t       kind;
    logic [6:0]  note;
    logic [15:0] on_delay;
    logic [15:0] duration;
    logic        last;
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TK_RD,
    S_TK_CHK,
    S_TK_FLUSH,
    S_ADD_ON,
    S_ADD_RD,
    S_ADD_OFF,
    S_ADD_WR,
    S_REL_RD,
    S_REL_OFF,
    S_CLR_RD,
    S_CLR_OFF
  } state_t;

endpackage
`default_nettype wire

/* rtl/msq_ram.sv */
`default_nettype none
module msq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/msq_cfg.sv */
`default_nettype none
module msq_cfg
  import msq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_KEY_OFFSET:  cfg_nxt.key_offset       = wr_data[6:0];
        CFG_LAST_STEP:   cfg_nxt.last_step        = wr_data[7:0];
        CFG_VELOCITY:    cfg_nxt.velocity         = wr_data[6:0];
        CFG_CHANNEL:     cfg_nxt.channel          = wr_data[3:0];
        CFG_DEFAULT_DUR: cfg_nxt.default_duration = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_offset       <= RST_KEY_OFFSET;
      cfg_r.last_step        <= RST_LAST_STEP;
      cfg_r.velocity         <= RST_VELOCITY;
      cfg_r.channel          <= RST_CHANNEL;
      cfg_r.default_duration <= RST_DEFAULT_DUR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/midi_step_sequencer.sv */
`default_nettype none
// Loop step sequencer with a note table of CAPACITY entries kept as a ring in one
// single-port-read RAM. One request is taken at a time; in_stall stays high until the
// sequencer returns to idle. The single RAM read port sets the pace: a tick or a clear
// walks the table one stored note at a time, reading each before it acts; an add emits
// its note-on, then on a full table reads and evicts the oldest note; a release reads
// the newest note and emits its note-off. Results pass through one output register,
// so out_stall can hold any emitting state. Eviction moves the ring head, nothing is
// copied. Entries need no clearing pass after reset; count and head are reset.
module midi_step_sequencer
  import msq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [6:0]             in_note_index,
  input  wire logic [15:0]            in_offset_ms,
  input  wire logic [15:0]            in_held_ms,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_status_byte,
  output logic [6:0]                  out_key,
  output logic [6:0]                  out_vel,
  output logic [15:0]                 out_on_delay,
  output logic [16:0]                 out_off_delay,
  output logic                        out_last,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  // ring pointer plus offset, offset at most CAPACITY
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] sum;
    sum = SW'(p) + SW'(n);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  cfg_t cfg;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic          pend_v_r, pend_v_nxt;
  entry_t        pend_r, pend_nxt;
  logic [6:0]    note_r, note_nxt;
  logic [15:0]   offset_r, offset_nxt;
  logic [15:0]   held_r, held_nxt;

  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [7:0]    out_status_r, out_status_nxt;
  logic [6:0]    out_key_r, out_key_nxt;
  logic [6:0]    out_vel_r, out_vel_nxt;
  logic [15:0]   out_on_r, out_on_nxt;
  logic [16:0]   out_off_r, out_off_nxt;
  logic          out_last_r, out_last_nxt;

  logic                        ram_we, ram_re;
  logic [PW-1:0]               ram_waddr;
  logic [$bits(entry_t)-1:0]   ram_wdata, ram_rdata;
  entry_t                      rd;
  entry_t                      wr_ent;

  emit_t         em;
  logic          free;
  logic          full;
  logic          match;
  logic          scan_end;
  logic [7:0]    pos_adv;

  msq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  msq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign ram_wdata = wr_ent;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  assign free     = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(CAPACITY));
  assign match    = (rd.step == pos_r);
  assign scan_end = (idx_r == count_r - CW'(1));
  assign pos_adv  = (pos_r == cfg.last_step) ? 8'd0 : pos_r + 8'd1;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    rptr_nxt   = rptr_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    note_nxt   = note_r;
    offset_nxt = offset_r;
    held_nxt   = held_r;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = rptr_r;
    wr_ent     = rd;
    em         = '0;
    em.kind    = KIND_ON;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          note_nxt   = in_note_index;
          offset_nxt = in_offset_ms;
          held_nxt   = in_held_ms;
          case (op_t'(in_op))
            OP_TICK: begin
              idx_nxt    = '0;
              rptr_nxt   = head_r;
              pend_v_nxt = 1'b0;
              state_nxt  = (count_r == '0) ? S_TK_FLUSH : S_TK_RD;
            end
            OP_ADD: begin
              state_nxt = S_ADD_ON;
            end
            OP_REL: begin
              if (count_r != '0) begin
                rptr_nxt  = ptr_add(head_r, count_r - CW'(1));
                state_nxt = S_REL_RD;
              end
            end
            OP_CLEAR: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                rptr_nxt  = head_r;
                state_nxt = S_CLR_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_TK_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_TK_CHK;
      end

      S_TK_CHK: begin
        // a match must push the held one out first; the final match is kept back
        // so it can carry last
        if (!(match && pend_v_r && !free)) begin
          if (match) begin
            if (pend_v_r) begin
              em.en       = 1'b1;
              em.kind     = KIND_SCHED;
              em.note     = pend_r.note;
              em.on_delay = pend_r.offset;
              em.duration = pend_r.duration;
            end
            pend_nxt   = rd;
            pend_v_nxt = 1'b1;
          end
          rptr_nxt  = ptr_add(rptr_r, CW'(1));
          idx_nxt   = idx_r + CW'(1);
          state_nxt = scan_end ? S_TK_FLUSH : S_TK_RD;
        end
      end

      S_TK_FLUSH: begin
        if (!pend_v_r || free) begin
          if (pend_v_r) begin
            em.en       = 1'b1;
            em.kind     = KIND_SCHED;
            em.note     = pend_r.note;
            em.on_delay = pend_r.offset;
            em.duration = pend_r.duration;
            em.last     = 1'b1;
          end
          pend_v_nxt = 1'b0;
          pos_nxt    = pos_adv;
          state_nxt  = S_IDLE;
        end
      end

      S_ADD_ON: begin
        if (free) begin
          em.en     = 1'b1;
          em.kind   = KIND_ON;
          em.note   = note_r;
          em.last   = !full;
          rptr_nxt  = head_r;
          state_nxt = full ? S_ADD_RD : S_ADD_WR;
        end
      end

      S_ADD_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_ADD_OFF;
      end

      S_ADD_OFF: begin
        if (free) begin
          em.en     = 1'b1;
          em.kind   = KIND_OFF;
          em.note   = rd.note;
          em.last   = 1'b1;
          head_nxt  = ptr_add(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
          state_nxt = S_ADD_WR;
        end
      end

      S_ADD_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = ptr_add(head_r, count_r);
        wr_ent.step     = pos_r;
        wr_ent.offset   = offset_r;
        wr_ent.duration = cfg.default_duration;
        wr_ent.note     = note_r;
        count_nxt       = count_r + CW'(1);
        state_nxt       = S_IDLE;
      end

      S_REL_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_REL_OFF;
      end

      S_REL_OFF: begin
        if (free) begin
          em.en           = 1'b1;
          em.kind         = KIND_OFF;
          em.note         = rd.note;
          em.last         = 1'b1;
          ram_we          = 1'b1;
          wr_ent.duration = held_r;
          state_nxt       = S_IDLE;
        end
      end

      S_CLR_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CLR_OFF;
      end

      S_CLR_OFF: begin
        if (free) begin
          em.en    = 1'b1;
          em.kind  = KIND_OFF;
          em.note  = rd.note;
          em.last  = scan_end;
          rptr_nxt = ptr_add(rptr_r, CW'(1));
          idx_nxt  = idx_r + CW'(1);
          if (scan_end) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CLR_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_vel_nxt    = out_vel_r;
    out_on_nxt     = out_on_r;
    out_off_nxt    = out_off_r;
    out_last_nxt   = out_last_r;
    if (em.en) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = em.kind;
      out_status_nxt = ((em.kind == KIND_OFF) ? STATUS_OFF : STATUS_ON) | {4'b0, cfg.channel};
      out_key_nxt    = em.note + cfg.key_offset;
      out_vel_nxt    = cfg.velocity;
      out_on_nxt     = em.on_delay;
      out_off_nxt    = 17'(em.on_delay) + 17'(em.duration);
      out_last_nxt   = em.last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      pos_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      pos_r       <= pos_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rptr_r       <= rptr_nxt;
    idx_r        <= idx_nxt;
    pend_r       <= pend_nxt;
    note_r       <= note_nxt;
    offset_r     <= offset_nxt;
    held_r       <= held_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_vel_r    <= out_vel_nxt;
    out_on_r     <= out_on_nxt;
    out_off_r    <= out_off_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status_byte = out_status_r;
  assign out_key         = out_key_r;
  assign out_vel         = out_vel_r;
  assign out_on_delay    = out_on_r;
  assign out_off_delay   = out_off_r;
  assign out_last        = out_last_r;

  // the table never holds more than its capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("note count above capacity");

  // storing a new note always finds a free slot
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_WR) |-> (count_r < CW'(CAPACITY)))
    else $error("add writes into a full table");

  // the loop position only moves at the end of a tick
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(pos_r)) |-> ($past(state_r) == S_TK_FLUSH))
    else $error("loop position moved outside a tick");

  // the ring head only moves on eviction
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(head_r)) |-> ($past(state_r) == S_ADD_OFF))
    else $error("table head moved outside an eviction");

  // no new result is loaded over one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !em.en)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

/* tb/msq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module msq_checker
  import msq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [6:0]             in_note_index,
  input  wire logic [15:0]            in_offset_ms,
  input  wire logic [15:0]            in_held_ms,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic [1:0]             out_kind,
  input  wire logic [7:0]             out_status_byte,
  input  wire logic [6:0]             out_key,
  input  wire logic [6:0]             out_vel,
  input  wire logic [15:0]            out_on_delay,
  input  wire logic [16:0]            out_off_delay,
  input  wire logic                   out_last,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  status;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [15:0] on_delay;
    logic [16:0] off_delay;
    logic        last;
  } midi_msg_t;

  midi_msg_t   msg_q[$];
  cfg_t        regs;
  entry_t      notes[CAPACITY];
  int unsigned note_cnt;
  logic [7:0]  step_pos;
  int          errs;

  function automatic midi_msg_t make_msg(kind_t k, logic [6:0] note, logic [15:0] on_d,
                                         logic [16:0] off_d);
    midi_msg_t m;
    m.kind      = k;
    m.status    = ((k == KIND_OFF) ? STATUS_OFF : STATUS_ON) + {4'd0, regs.channel};
    m.key       = note + regs.key_offset;  // wraps at 7 bits
    m.vel       = regs.velocity;
    m.on_delay  = on_d;
    m.off_delay = off_d;
    m.last      = 1'b0;
    return m;
  endfunction

  task automatic predict_request(op_t op, logic [6:0] note, logic [15:0] offs,
                                 logic [15:0] held);
    midi_msg_t batch[$];
    int unsigned i;
    case (op)
      OP_TICK: begin
        for (i = 0; i < note_cnt; i++) begin
          if (notes[i].step == step_pos) begin
            batch.push_back(make_msg(KIND_SCHED, notes[i].note, notes[i].offset,
                                     {1'b0, notes[i].offset} + {1'b0, notes[i].duration}));
          end
        end
        step_pos = (step_pos == regs.last_step) ? 8'd0 : step_pos + 8'd1;
      end
      OP_ADD: begin
        batch.push_back(make_msg(KIND_ON, note, 16'd0, 17'd0));
        if (note_cnt >= CAPACITY) begin
          batch.push_back(make_msg(KIND_OFF, notes[0].note, 16'd0, 17'd0));
          for (i = 0; i + 1 < note_cnt; i++) notes[i] = notes[i + 1];
          note_cnt--;
        end
        notes[note_cnt].step     = step_pos;
        notes[note_cnt].offset   = offs;
        notes[note_cnt].duration = regs.default_duration;
        notes[note_cnt].note     = note;
        note_cnt++;
      end
      OP_REL: begin
        if (note_cnt > 0) begin
          notes[note_cnt - 1].duration = held;
          batch.push_back(make_msg(KIND_OFF, notes[note_cnt - 1].note, 16'd0, 17'd0));
        end
      end
      default: begin
        for (i = 0; i < note_cnt; i++)
          batch.push_back(make_msg(KIND_OFF, notes[i].note, 16'd0, 17'd0));
        note_cnt = 0;
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[j]) msg_q.push_back(batch[j]);
  endtask

  task automatic check_result();
    midi_msg_t got;
    midi_msg_t want;
    got.kind      = kind_t'(out_kind);
    got.status    = out_status_byte;
    got.key       = out_key;
    got.vel       = out_vel;
    got.on_delay  = out_on_delay;
    got.off_delay = out_off_delay;
    got.last      = out_last;
    if (msg_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: result with nothing expected: kind=%0d st=%02h key=%0d last=%0b",
                 $time, out_kind, out_status_byte, out_key, out_last);
    end else begin
      want = msg_q.pop_front();
      if (got != want) begin
        errs++;
        if (errs <= 10) begin
          $display("%0t: mismatch, expected kind=%0d st=%02h key=%0d vel=%0d on=%0d off=%0d last=%0b",
                   $time, want.kind, want.status, want.key, want.vel, want.on_delay,
                   want.off_delay, want.last);
          $display("%0t:           actual   kind=%0d st=%02h key=%0d vel=%0d on=%0d off=%0d last=%0b",
                   $time, got.kind, got.status, got.key, got.vel, got.on_delay,
                   got.off_delay, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      msg_q.delete();
      regs.key_offset       = RST_KEY_OFFSET;
      regs.last_step        = RST_LAST_STEP;
      regs.velocity         = RST_VELOCITY;
      regs.channel          = RST_CHANNEL;
      regs.default_duration = RST_DEFAULT_DUR;
      note_cnt = 0;
      step_pos = 8'd0;
      errs     = 0;
    end else begin
      // one request in flight at a time, so results here belong to older requests
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        predict_request(op_t'(in_op), in_note_index, in_offset_ms, in_held_ms);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_OFFSET:  regs.key_offset       = cfg_data[6:0];
          CFG_LAST_STEP:   regs.last_step        = cfg_data[7:0];
          CFG_VELOCITY:    regs.velocity         = cfg_data[6:0];
          CFG_CHANNEL:     regs.channel          = cfg_data[3:0];
          CFG_DEFAULT_DUR: regs.default_duration = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending    <= msg_q.size();
    fail_count <= errs;
  end

endmodule
`default_nettype wire

/* tb/tb_midi_step_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_midi_step_sequencer;
  import msq_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int          TAIL     = 2 * CAPACITY + 20;  // one full table walk
  localparam int          LIMIT    = 3_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_op;
  logic [6:0]             in_note_index;
  logic [15:0]            in_offset_ms;
  logic [15:0]            in_held_ms;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             out_kind;
  logic [7:0]             out_status_byte;
  logic [6:0]             out_key;
  logic [6:0]             out_vel;
  logic [15:0]            out_on_delay;
  logic [16:0]            out_off_delay;
  logic                   out_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     cycle_cnt;

  midi_step_sequencer #(.CAPACITY(CAPACITY)) dut (.*);

  msq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_midi_step_sequencer: FAIL");
      $finish;
    end
  end

  // result side back-pressure: free runs, solid stalls and choppy stretches
  initial begin : stall_gen
    int run;
    int mode;
    int k;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      if (mode == 1)
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      else
        run = $urandom_range(1, 40);
      for (k = 0; k < run; k++) begin
        @(posedge clk);
        out_stall <= (mode == 1) ? 1'b1 : (mode == 2) ? 1'($urandom_range(0, 1)) : 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_req(op_t op, logic [6:0] note, logic [15:0] offs, logic [15:0] held);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_note_index <= note;
    in_offset_ms  <= offs;
    in_held_ms    <= held;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending until every predicted result is out, then optionally let a walk end
  task automatic drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(logic [6:0] key_ofs, logic [7:0] last_stp, logic [6:0] vel,
                           logic [3:0] chan, logic [15:0] dur);
    put_reg(CFG_KEY_OFFSET, {9'd0, key_ofs});
    put_reg(CFG_LAST_STEP, {8'd0, last_stp});
    put_reg(CFG_VELOCITY, {9'd0, vel});
    put_reg(CFG_CHANNEL, {12'd0, chan});
    put_reg(CFG_DEFAULT_DUR, dur);
    cfg_valid <= 1'b0;
  endtask

  task automatic play_random(int count, int add_pct, int tick_pct, int rel_pct);
    int n;
    int r;
    op_t op;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) op = OP_ADD;
      else if (r < add_pct + tick_pct) op = OP_TICK;
      else if (r < add_pct + tick_pct + rel_pct) op = OP_REL;
      else op = OP_CLEAR;
      send_req(op, 7'($urandom_range(0, 79)), pick_ms(), pick_ms());
      if ($urandom_range(0, 49) == 0) drain(0);
    end
  endtask

  initial begin : stim
    cycle_cnt     <= 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_TICK;
    in_note_index <= 7'd0;
    in_offset_ms  <= 16'd0;
    in_held_ms    <= 16'd0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_KEY_OFFSET;
    cfg_data      <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, empty table
    send_req(OP_REL, 7'd0, 16'd0, 16'hFFFF);      // release on empty: no result
    send_req(OP_CLEAR, 7'd79, 16'hFFFF, 16'd0);   // clear on empty: no result
    send_req(OP_TICK, 7'd0, 16'd0, 16'd0);        // nothing scheduled, step 0 -> 1
    send_req(OP_ADD, 7'd0, 16'd0, 16'hFFFF);
    send_req(OP_ADD, 7'd79, 16'hFFFF, 16'd0);     // highest key
    send_req(OP_TICK, 7'd79, 16'hFFFF, 16'hFFFF); // both notes sit on step 1
    send_req(OP_REL, 7'd0, 16'd0, 16'hFFFF);
    send_req(OP_ADD, 7'd42, 16'h5555, 16'd0);
    send_req(OP_REL, 7'd0, 16'd0, 16'hAAAA);
    send_req(OP_TICK, 7'd0, 16'd0, 16'd0);
    send_req(OP_CLEAR, 7'd0, 16'd0, 16'd0);
    drain(TAIL);

    // top values; position 3 now sits above last_step
    load_regs(7'd127, 8'd0, 7'd127, 4'd15, 16'hFFFF);
    send_req(OP_ADD, 7'd79, 16'hFFFF, 16'd0);     // key wraps
    send_req(OP_TICK, 7'd0, 16'd0, 16'd0);        // widest off delay
    send_req(OP_ADD, 7'd1, 16'd0, 16'hFFFF);
    send_req(OP_REL, 7'd1, 16'hFFFF, 16'd0);
    send_req(OP_CLEAR, 7'd0, 16'd0, 16'd0);
    drain(TAIL);

    // position 4 above last_step 2: it keeps counting up past last_step
    load_regs(7'($urandom_range(0, 127)), 8'd2, 7'($urandom_range(0, 127)),
              4'($urandom_range(0, 15)), pick_ms());
    play_random(30, 12, 85, 3);
    drain(TAIL);
    load_regs(7'($urandom_range(0, 127)), 8'd255, 7'($urandom_range(0, 127)),
              4'($urandom_range(0, 15)), pick_ms());
    send_req(OP_CLEAR, 7'd0, 16'd0, 16'd0);
    drain(TAIL);

    // fill past capacity so adds start evicting
    load_regs(7'($urandom_range(0, 127)), 8'($urandom_range(2, 5)),
              7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)), pick_ms());
    play_random(80, 90, 5, 5);
    drain(TAIL);

    // full table, tick heavy
    load_regs(7'($urandom_range(0, 127)), 8'($urandom_range(5, 9)),
              7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)), pick_ms());
    play_random(30, 35, 50, 10);
    drain(TAIL);

    load_regs(7'd0, 8'($urandom_range(9, 15)), 7'd0, 4'd0, 16'd0);
    play_random(25, 45, 35, 10);
    drain(TAIL);

    if (fail_count == 0 && pending == 0)
      $display("tb_midi_step_sequencer: PASS");
    else
      $display("tb_midi_step_sequencer: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
